// File: rtl/lmst_pkg.sv
// Shared types, codes and constants of the lazy min segment tree unit.
`timescale 1ns / 1ps
`default_nettype none
package lmst_pkg;

	localparam int POS_W   = 10;
	localparam int IDX_W   = POS_W + 1;
	localparam int MODE_W  = 2;
	localparam int DATA_W  = 32;
	localparam int STK_D   = POS_W;
	localparam int SP_W    = $clog2(STK_D + 1);
	localparam int NEUTRAL = 1 << 26;
	localparam int ACC_MIN_W = 28;

	localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOWER = 2'd1;
	localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

	localparam logic [2:0] WR_NONE  = 3'd0;
	localparam logic [2:0] WR_ZERO  = 3'd1;
	localparam logic [2:0] WR_ADD   = 3'd2;
	localparam logic [2:0] WR_LOWER = 3'd3;
	localparam logic [2:0] WR_PUSH  = 3'd4;
	localparam logic [2:0] WR_KEEP  = 3'd5;
	localparam logic [2:0] WR_PULL  = 3'd6;

	localparam logic [1:0] RD_NONE  = 2'd0;
	localparam logic [1:0] RD_CUR   = 2'd1;
	localparam logic [1:0] RD_LEFT  = 2'd2;
	localparam logic [1:0] RD_RIGHT = 2'd3;

	typedef struct packed {
		logic       load;
		logic       init;
		logic [1:0] rd_sel;
		logic [2:0] wr_op;
		logic       wr_right;
		logic       cap_node;
		logic       cap_left;
		logic       acc_upd;
		logic       desc_left;
		logic       desc_right;
		logic       ret_right;
		logic       ret_pop;
		logic       emit;
		logic       emit_neutral;
	} lmst_cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              nop;
		logic              q_empty;
		logic              covered;
		logic              leaf;
		logic              lower_wr;
		logic              pend_nz;
		logic              need_left;
		logic              need_right;
		logic              top_left;
		logic              top_need_right;
		logic              sp_zero;
		logic              clr_last;
	} lmst_stat_t;

endpackage
`default_nettype wire

// File: rtl/lmst_datapath.sv
// Datapath: node memory, walk stack, range bounds, saturating adders, result register.
`timescale 1ns / 1ps
`default_nettype none
module lmst_datapath #(
	parameter int LEAVES     = 1024,
	parameter int VALUE_BITS = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [lmst_pkg::POS_W-1:0]        cfg_data,
	input  wire logic [lmst_pkg::MODE_W-1:0]       mode,
	input  wire logic [lmst_pkg::POS_W-1:0]        range_low,
	input  wire logic [lmst_pkg::POS_W-1:0]        range_high,
	input  wire logic [lmst_pkg::POS_W-1:0]        position,
	input  wire logic signed [lmst_pkg::DATA_W-1:0] value,
	input  wire lmst_pkg::lmst_cmd_t               cmd,
	output lmst_pkg::lmst_stat_t                   stat,
	output logic signed [lmst_pkg::DATA_W-1:0]     minimum
);

	localparam int VB         = VALUE_BITS;
	localparam int PW         = lmst_pkg::POS_W;
	localparam int IW         = lmst_pkg::IDX_W;
	localparam int NODE_COUNT = 2 * LEAVES;
	localparam int AW         = $clog2(NODE_COUNT);
	localparam int CW         = ((AW > IW) ? AW : IW) + 1;
	localparam int EW         = (VB > lmst_pkg::DATA_W) ? VB : lmst_pkg::DATA_W;
	localparam int ACC_W      = (VB > lmst_pkg::ACC_MIN_W) ? VB : lmst_pkg::ACC_MIN_W;
	localparam int LIM_CAP    = (LEAVES - 1 > (1 << PW) - 1) ? (1 << PW) - 1 : LEAVES - 1;
	localparam int SPW        = lmst_pkg::SP_W;

	localparam logic [EW-1:0]        VMAX_U = {1'b0, {(EW-1){1'b1}}} >> (EW - VB);
	localparam logic signed [EW-1:0] VMAX_E = signed'(VMAX_U);
	localparam logic signed [EW-1:0] VMIN_E = ~VMAX_E;
	localparam logic signed [VB-1:0] VMAX_V = {1'b0, {(VB-1){1'b1}}};
	localparam logic signed [VB-1:0] VMIN_V = {1'b1, {(VB-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] NEUT_A = ACC_W'(lmst_pkg::NEUTRAL);
	localparam logic [lmst_pkg::DATA_W-1:0] NEUT_O = lmst_pkg::DATA_W'(lmst_pkg::NEUTRAL);

	typedef struct packed {
		logic [IW-1:0] c;
		logic [PW-1:0] l;
		logic [PW-1:0] r;
		logic          right;
	} frame_t;

	logic [PW-1:0]              last_index_q;
	logic [lmst_pkg::MODE_W-1:0] mode_q;
	logic [PW-1:0]              lo_q, hi_q, pos_q;
	logic signed [VB-1:0]       x_q;
	logic [IW-1:0]              cur_c_q;
	logic [PW-1:0]              cur_l_q, cur_r_q;
	logic [SPW-1:0]             sp_q;
	frame_t                     stk_q [lmst_pkg::STK_D];
	logic signed [VB-1:0]       nmin_q, pend_q, a_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic [lmst_pkg::DATA_W-1:0] minimum_q;
	logic [AW-1:0]              clr_q;
	logic [2*VB-1:0]            mem [NODE_COUNT];
	logic [2*VB-1:0]            mem_q;
	logic                       rng_q;

	function automatic logic signed [VB-1:0] sat_add(input logic signed [VB-1:0] a,
	                                                 input logic signed [VB-1:0] b);
		logic [VB:0] s;
		s = {a[VB-1], a} + {b[VB-1], b};
		if (s[VB] != s[VB-1]) begin
			sat_add = s[VB] ? VMIN_V : VMAX_V;
		end else begin
			sat_add = s[VB-1:0];
		end
	endfunction

	function automatic logic [PW-1:0] mid(input logic [PW-1:0] l, input logic [PW-1:0] r);
		logic [PW:0] s;
		s = {1'b0, l} + {1'b0, r};
		mid = s[PW:1];
	endfunction

	logic [PW-1:0]        lim, hi_c, cur_m, top_m;
	logic                 empty;
	logic signed [EW-1:0] v_e, v_sat;
	logic [2*VB-1:0]      rd_word;
	logic signed [VB-1:0] rd_min, rd_pend;
	logic [SPW-1:0]       top_idx;
	frame_t               top;
	logic [IW-1:0]        left_c, right_c, rsel_c, wsel_c;
	logic [CW-1:0]        rc_e, wc_e;
	logic                 we;
	logic [2*VB-1:0]      wdata;
	logic signed [ACC_W-1:0] rd_x;
	logic signed [ACC_W+lmst_pkg::DATA_W-1:0] acc_x;
	logic                 is_lower;

	assign lim   = (last_index_q > PW'(LIM_CAP)) ? PW'(LIM_CAP) : last_index_q;
	assign empty = (lo_q > hi_q) || (lo_q > lim);
	assign hi_c  = (hi_q > lim) ? lim : hi_q;

	assign v_e   = EW'(value);
	assign v_sat = (v_e > VMAX_E) ? VMAX_E : ((v_e < VMIN_E) ? VMIN_E : v_e);

	assign rd_word = rng_q ? mem_q : '0;
	assign rd_min  = signed'(rd_word[2*VB-1:VB]);
	assign rd_pend = signed'(rd_word[VB-1:0]);
	assign rd_x    = ACC_W'(rd_min);

	assign top_idx = (sp_q == '0) ? '0 : sp_q - SPW'(1);
	assign top     = stk_q[top_idx];
	assign cur_m   = mid(cur_l_q, cur_r_q);
	assign top_m   = mid(top.l, top.r);
	assign left_c  = {cur_c_q[IW-2:0], 1'b0};
	assign right_c = {cur_c_q[IW-2:0], 1'b1};
	assign is_lower = (mode_q == lmst_pkg::MODE_LOWER);

	always_comb begin
		unique case (cmd.rd_sel)
			lmst_pkg::RD_LEFT:  rsel_c = left_c;
			lmst_pkg::RD_RIGHT: rsel_c = right_c;
			lmst_pkg::RD_CUR:   rsel_c = cur_c_q;
			default:            rsel_c = cur_c_q;
		endcase
	end
	assign rc_e = CW'(rsel_c);

	always_comb begin
		we     = 1'b0;
		wsel_c = cur_c_q;
		wdata  = '0;
		unique case (cmd.wr_op)
			lmst_pkg::WR_ADD: begin
				we    = 1'b1;
				wdata = {sat_add(rd_min, x_q), sat_add(rd_pend, x_q)};
			end
			lmst_pkg::WR_LOWER: begin
				we    = 1'b1;
				wdata = {x_q, rd_pend};
			end
			lmst_pkg::WR_PUSH: begin
				we     = 1'b1;
				wsel_c = cmd.wr_right ? right_c : left_c;
				wdata  = {sat_add(rd_min, pend_q), sat_add(rd_pend, pend_q)};
			end
			lmst_pkg::WR_KEEP: begin
				we    = 1'b1;
				wdata = {nmin_q, {VB{1'b0}}};
			end
			lmst_pkg::WR_PULL: begin
				we    = 1'b1;
				wdata = {((a_q < rd_min) ? a_q : rd_min), {VB{1'b0}}};
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end
	assign wc_e = CW'(wsel_c);

	// memory write port; nodes beyond storage drop their writes
	always_ff @(posedge clk) begin
		if (cmd.wr_op == lmst_pkg::WR_ZERO) begin
			mem[clr_q] <= '0;
		end else if (we && (wc_e < CW'(NODE_COUNT))) begin
			mem[wc_e[AW-1:0]] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_sel != lmst_pkg::RD_NONE) begin
			mem_q <= mem[rc_e[AW-1:0]];
			rng_q <= (rc_e < CW'(NODE_COUNT));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_index_q <= PW'(1023);
			clr_q        <= '0;
			sp_q         <= '0;
		end else begin
			if (cfg_we) begin
				last_index_q <= cfg_data;
			end
			if (cmd.wr_op == lmst_pkg::WR_ZERO) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.init) begin
				sp_q <= '0;
			end else if (cmd.desc_left || cmd.desc_right) begin
				sp_q <= sp_q + SPW'(1);
			end else if (cmd.ret_pop) begin
				sp_q <= sp_q - SPW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			lo_q   <= range_low;
			hi_q   <= range_high;
			pos_q  <= position;
			x_q    <= v_sat[VB-1:0];
		end
		if (cmd.init) begin
			cur_c_q <= IW'(1);
			cur_l_q <= '0;
			cur_r_q <= lim;
			acc_q   <= NEUT_A;
		end else if (cmd.desc_left) begin
			stk_q[sp_q] <= '{c: cur_c_q, l: cur_l_q, r: cur_r_q, right: 1'b0};
			cur_c_q     <= left_c;
			cur_r_q     <= cur_m;
		end else if (cmd.desc_right) begin
			stk_q[sp_q] <= '{c: cur_c_q, l: cur_l_q, r: cur_r_q, right: 1'b1};
			cur_c_q     <= right_c;
			cur_l_q     <= cur_m + PW'(1);
		end else if (cmd.ret_right) begin
			stk_q[top_idx].right <= 1'b1;
			cur_c_q <= {top.c[IW-2:0], 1'b1};
			cur_l_q <= top_m + PW'(1);
			cur_r_q <= top.r;
		end else if (cmd.ret_pop) begin
			cur_c_q <= top.c;
			cur_l_q <= top.l;
			cur_r_q <= top.r;
		end
		if (cmd.cap_node) begin
			nmin_q <= rd_min;
			pend_q <= rd_pend;
		end
		if (cmd.cap_left) begin
			a_q <= rd_min;
		end
		// a root that the range covers returns its own minimum, not capped by neutral
		if (cmd.acc_upd) begin
			acc_q <= (sp_q == '0) ? rd_x : ((rd_x < acc_q) ? rd_x : acc_q);
		end
		if (cmd.emit) begin
			minimum_q <= cmd.emit_neutral ? NEUT_O : acc_x[lmst_pkg::DATA_W-1:0];
		end
	end

	assign acc_x   = (ACC_W + lmst_pkg::DATA_W)'(acc_q);
	assign minimum = signed'(minimum_q);

	always_comb begin
		stat.mode     = mode_q;
		stat.nop      = ((mode_q != lmst_pkg::MODE_ADD) && (mode_q != lmst_pkg::MODE_LOWER)
		                 && (mode_q != lmst_pkg::MODE_QUERY))
		                || ((mode_q == lmst_pkg::MODE_ADD) && empty)
		                || (is_lower && (pos_q > lim));
		stat.q_empty  = (mode_q == lmst_pkg::MODE_QUERY) && empty;
		stat.covered  = (lo_q <= cur_l_q) && (cur_r_q <= hi_c);
		stat.leaf     = (cur_l_q == cur_r_q);
		stat.lower_wr = (x_q < rd_min);
		stat.pend_nz  = (rd_pend != '0);
		stat.need_left  = is_lower ? (pos_q <= cur_m) : (lo_q <= cur_m);
		stat.need_right = is_lower ? (pos_q > cur_m) : (hi_c > cur_m);
		stat.top_left   = !top.right;
		stat.top_need_right = is_lower ? (pos_q > top_m) : (hi_c > top_m);
		stat.sp_zero  = (sp_q == '0);
		stat.clr_last = (clr_q == AW'(NODE_COUNT - 1));
	end

endmodule
`default_nettype wire

// File: rtl/lmst_ctrl.sv
// Controller: sequences the tree walk, push-downs, pull-ups and the clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module lmst_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	output logic                      strobe,
	input  wire lmst_pkg::lmst_stat_t stat,
	output lmst_pkg::lmst_cmd_t       cmd
);

	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_LOAD   = 4'd2;
	localparam logic [3:0] S_RD     = 4'd3;
	localparam logic [3:0] S_EVAL   = 4'd4;
	localparam logic [3:0] S_PL_RD  = 4'd5;
	localparam logic [3:0] S_PL_WR  = 4'd6;
	localparam logic [3:0] S_PR_WR  = 4'd7;
	localparam logic [3:0] S_PC_WR  = 4'd8;
	localparam logic [3:0] S_DESC   = 4'd9;
	localparam logic [3:0] S_RET    = 4'd10;
	localparam logic [3:0] S_PU_RD  = 4'd11;
	localparam logic [3:0] S_PU_RD2 = 4'd12;
	localparam logic [3:0] S_PU_WR  = 4'd13;

	logic [3:0] state_q, state_d;
	logic       strobe_q;
	logic       is_query;

	assign is_query = (stat.mode == lmst_pkg::MODE_QUERY);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.wr_op = lmst_pkg::WR_ZERO;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_LOAD;
				end
			end
			S_LOAD: begin
				priority if (stat.nop) begin
					state_d = S_IDLE;
				end else if (stat.q_empty) begin
					cmd.emit         = 1'b1;
					cmd.emit_neutral = 1'b1;
					state_d          = S_IDLE;
				end else begin
					cmd.init = 1'b1;
					state_d  = S_RD;
				end
			end
			S_RD: begin
				cmd.rd_sel = lmst_pkg::RD_CUR;
				state_d    = S_EVAL;
			end
			S_EVAL: begin
				cmd.cap_node = 1'b1;
				priority if (is_query && stat.covered) begin
					cmd.acc_upd = 1'b1;
					state_d     = S_RET;
				end else if ((stat.mode == lmst_pkg::MODE_ADD) && stat.covered) begin
					cmd.wr_op = lmst_pkg::WR_ADD;
					state_d   = S_RET;
				end else if ((stat.mode == lmst_pkg::MODE_LOWER) && stat.leaf) begin
					if (stat.lower_wr) begin
						cmd.wr_op = lmst_pkg::WR_LOWER;
					end
					state_d = S_RET;
				end else if (stat.pend_nz) begin
					state_d = S_PL_RD;
				end else begin
					state_d = S_DESC;
				end
			end
			S_PL_RD: begin
				cmd.rd_sel = lmst_pkg::RD_LEFT;
				state_d    = S_PL_WR;
			end
			S_PL_WR: begin
				cmd.wr_op  = lmst_pkg::WR_PUSH;
				cmd.rd_sel = lmst_pkg::RD_RIGHT;
				state_d    = S_PR_WR;
			end
			S_PR_WR: begin
				cmd.wr_op    = lmst_pkg::WR_PUSH;
				cmd.wr_right = 1'b1;
				state_d      = S_PC_WR;
			end
			S_PC_WR: begin
				cmd.wr_op = lmst_pkg::WR_KEEP;
				state_d   = S_DESC;
			end
			S_DESC: begin
				priority if (stat.need_left) begin
					cmd.desc_left = 1'b1;
					state_d       = S_RD;
				end else if (stat.need_right) begin
					cmd.desc_right = 1'b1;
					state_d        = S_RD;
				end else begin
					state_d = is_query ? S_RET : S_PU_RD;
				end
			end
			S_RET: begin
				priority if (stat.sp_zero) begin
					cmd.emit = is_query;
					state_d  = S_IDLE;
				end else if (stat.top_left && stat.top_need_right) begin
					cmd.ret_right = 1'b1;
					state_d       = S_RD;
				end else begin
					// queries leave minimums alone, so skip the pull-up
					cmd.ret_pop = 1'b1;
					state_d     = is_query ? S_RET : S_PU_RD;
				end
			end
			S_PU_RD: begin
				cmd.rd_sel = lmst_pkg::RD_LEFT;
				state_d    = S_PU_RD2;
			end
			S_PU_RD2: begin
				cmd.cap_left = 1'b1;
				cmd.rd_sel   = lmst_pkg::RD_RIGHT;
				state_d      = S_PU_WR;
			end
			S_PU_WR: begin
				cmd.wr_op = lmst_pkg::WR_PULL;
				state_d   = S_RET;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= cmd.emit;
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign strobe = strobe_q;

endmodule
`default_nettype wire

// File: rtl/lazy_min_segment_tree_unit.sv
// Lazy segment tree, range add / point lower / range minimum: top level.
// After reset, busy stays high for a clearing pass that zeroes the node memory.
// One item at a time: a no-op item returns to idle after its load step; others read and evaluate
// each node visited, with further steps per push-down and pull-up, at one node memory read per cycle.
// A query result appears on minimum with strobe in the cycle after the walk ends; the receiver
// cannot stall, and the next item may be started in that same cycle.
`timescale 1ns / 1ps
`default_nettype none
module lazy_min_segment_tree_unit #(
	parameter int LEAVES     = 1024,
	parameter int VALUE_BITS = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [lmst_pkg::POS_W-1:0]           cfg_data,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic [lmst_pkg::MODE_W-1:0]          mode,
	input  wire logic [lmst_pkg::POS_W-1:0]           range_low,
	input  wire logic [lmst_pkg::POS_W-1:0]           range_high,
	input  wire logic [lmst_pkg::POS_W-1:0]           position,
	input  wire logic signed [lmst_pkg::DATA_W-1:0]   value,
	output logic                                      strobe,
	output logic signed [lmst_pkg::DATA_W-1:0]        minimum
);

	lmst_pkg::lmst_cmd_t  cmd;
	lmst_pkg::lmst_stat_t stat;

	lmst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.strobe (strobe),
		.stat   (stat),
		.cmd    (cmd)
	);

	lmst_datapath #(
		.LEAVES     (LEAVES),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.mode       (mode),
		.range_low  (range_low),
		.range_high (range_high),
		.position   (position),
		.value      (value),
		.cmd        (cmd),
		.stat       (stat),
		.minimum    (minimum)
	);

endmodule
`default_nettype wire

// File: rtl/lmst_checker.sv
// Port-level checker for the lazy min segment tree unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lmst_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic strobe
);

	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !busy)
		else $error("result strobe while busy");

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe)
		else $error("back-to-back result strobes");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	a_strobe_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result without preceding work");

endmodule

bind lazy_min_segment_tree_unit lmst_checker u_lmst_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.strobe (strobe)
);
`default_nettype wire

// File: tb/sv/tb_lazy_min_segment_tree_unit.sv
// Self-checking testbench for the lazy min segment tree unit.
`timescale 1ns / 1ps
module tb_lazy_min_segment_tree_unit;

	localparam int LEAVES = 1024;
	localparam int NODES = 2 * LEAVES;
	localparam longint VMAX = 64'sd2147483647;
	localparam longint VMIN = -64'sd2147483648;
	localparam int LIMIT = 4000000;
	localparam logic [lmst_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [lmst_pkg::POS_W-1:0] cfg_data = '0;
	logic start = 0;
	logic busy;
	logic [lmst_pkg::MODE_W-1:0] mode = lmst_pkg::MODE_ADD;
	logic [lmst_pkg::POS_W-1:0] range_low = '0, range_high = '0, position = '0;
	logic signed [lmst_pkg::DATA_W-1:0] value = '0;
	logic strobe;
	logic signed [lmst_pkg::DATA_W-1:0] minimum;

	lazy_min_segment_tree_unit DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.start(start), .busy(busy), .mode(mode), .range_low(range_low),
		.range_high(range_high), .position(position), .value(value),
		.strobe(strobe), .minimum(minimum)
	);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// Shadow tree
	longint tree_min[NODES];
	longint tree_lazy[NODES];
	int unsigned span_last;
	logic signed [lmst_pkg::DATA_W-1:0] min_queue[$];
	int errors = 0;
	int n_items = 0, n_queries = 0, n_adds = 0, n_lowers = 0, n_nops = 0;
	longint cycles = 0;

	function automatic longint clamp_add(longint a, longint b);
		longint s;
		s = a + b;
		if (s > VMAX) return VMAX;
		if (s < VMIN) return VMIN;
		return s;
	endfunction

	function automatic void push_lazy(int unsigned c);
		longint p;
		p = tree_lazy[c];
		if (p == 0) return;
		for (int unsigned k = 2 * c; k <= 2 * c + 1; k++) begin
			tree_lazy[k] = clamp_add(tree_lazy[k], p);
			tree_min[k] = clamp_add(tree_min[k], p);
		end
		tree_lazy[c] = 0;
	endfunction

	function automatic void pull_min(int unsigned c);
		tree_min[c] = tree_min[2*c] < tree_min[2*c+1] ? tree_min[2*c] : tree_min[2*c+1];
	endfunction

	function automatic void add_range(int unsigned c, int unsigned l, int unsigned r,
			int unsigned lo, int unsigned hi, longint x);
		int unsigned m;
		if (lo <= l && r <= hi) begin
			tree_lazy[c] = clamp_add(tree_lazy[c], x);
			tree_min[c] = clamp_add(tree_min[c], x);
			return;
		end
		push_lazy(c);
		m = (l + r) >> 1;
		if (lo <= m) add_range(2 * c, l, m, lo, hi, x);
		if (hi > m) add_range(2 * c + 1, m + 1, r, lo, hi, x);
		pull_min(c);
	endfunction

	function automatic void lower_point(int unsigned c, int unsigned l, int unsigned r,
			int unsigned p, longint x);
		int unsigned m;
		if (l == r) begin
			if (x < tree_min[c]) tree_min[c] = x;
			return;
		end
		m = (l + r) >> 1;
		push_lazy(c);
		if (p <= m) lower_point(2 * c, l, m, p, x);
		else lower_point(2 * c + 1, m + 1, r, p, x);
		pull_min(c);
	endfunction

	function automatic longint min_range(int unsigned c, int unsigned l, int unsigned r,
			int unsigned lo, int unsigned hi);
		int unsigned m;
		longint res, t;
		res = lmst_pkg::NEUTRAL;
		if (lo <= l && r <= hi) return tree_min[c];
		m = (l + r) >> 1;
		push_lazy(c);
		if (lo <= m) begin
			t = min_range(2 * c, l, m, lo, hi);
			if (t < res) res = t;
		end
		if (hi > m) begin
			t = min_range(2 * c + 1, m + 1, r, lo, hi);
			if (t < res) res = t;
		end
		return res;
	endfunction

	// Apply one item to the shadow tree; queue the minimum for a query.
	function automatic void predict_item(logic [lmst_pkg::MODE_W-1:0] md, int unsigned lo,
			int unsigned hi, int unsigned pos, logic signed [lmst_pkg::DATA_W-1:0] v);
		bit empty;
		longint res;
		empty = (lo > hi) || (lo > span_last);
		if (hi > span_last) hi = span_last;
		case (md)
			lmst_pkg::MODE_ADD:
				if (!empty) add_range(1, 0, span_last, lo, hi, longint'(v));
			lmst_pkg::MODE_LOWER:
				if (pos <= span_last) lower_point(1, 0, span_last, pos, longint'(v));
			lmst_pkg::MODE_QUERY: begin
				res = empty ? lmst_pkg::NEUTRAL : min_range(1, 0, span_last, lo, hi);
				min_queue = {min_queue, res[lmst_pkg::DATA_W-1:0]};
			end
			default: ;
		endcase
	endfunction

	// Result checker
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (min_queue.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0d", $time, minimum);
				errors++;
			end else begin
				if (minimum !== min_queue[0]) begin
					$display("%0t: minimum mismatch, expected %0d, actual %0d",
						$time, min_queue[0], minimum);
					errors++;
				end
				void'(min_queue.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_lazy_min_segment_tree_unit failed");
			$finish;
		end
	end

	typedef struct {
		logic [lmst_pkg::MODE_W-1:0] md;
		int unsigned lo, hi, pos;
		logic signed [lmst_pkg::DATA_W-1:0] v;
		bit has_exp;
		logic signed [lmst_pkg::DATA_W-1:0] exp_min;
	} stim_row_t;

	stim_row_t directed[$];

	function automatic stim_row_t row(logic [lmst_pkg::MODE_W-1:0] md, int unsigned lo,
			int unsigned hi, int unsigned pos, logic signed [lmst_pkg::DATA_W-1:0] v,
			bit has_exp, logic signed [lmst_pkg::DATA_W-1:0] e);
		stim_row_t r;
		r.md = md; r.lo = lo; r.hi = hi; r.pos = pos; r.v = v;
		r.has_exp = has_exp; r.exp_min = e;
		return r;
	endfunction

	function automatic void add_row(logic [lmst_pkg::MODE_W-1:0] md, int unsigned lo,
			int unsigned hi, int unsigned pos, logic signed [lmst_pkg::DATA_W-1:0] v,
			bit has_exp, logic signed [lmst_pkg::DATA_W-1:0] e);
		directed = {directed, row(md, lo, hi, pos, v, has_exp, e)};
	endfunction

	// Hold start high across back-to-back items; drop it only for an idle gap.
	task automatic send_item(logic [lmst_pkg::MODE_W-1:0] md, int unsigned lo, int unsigned hi,
			int unsigned pos, logic signed [lmst_pkg::DATA_W-1:0] v);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		mode <= md;
		range_low <= lo[lmst_pkg::POS_W-1:0];
		range_high <= hi[lmst_pkg::POS_W-1:0];
		position <= pos[lmst_pkg::POS_W-1:0];
		value <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_item(md, lo, hi, pos, v);
		n_items++;
		case (md)
			lmst_pkg::MODE_ADD: n_adds++;
			lmst_pkg::MODE_LOWER: n_lowers++;
			lmst_pkg::MODE_QUERY: n_queries++;
			default: n_nops++;
		endcase
	endtask

	task automatic drain();
		start <= 0;
		while (min_queue.size() != 0) @(posedge clk);
		// no-result items may still be walking
		repeat (20) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_span(int unsigned last);
		cfg_we <= 1;
		cfg_data <= last[lmst_pkg::POS_W-1:0];
		@(posedge clk);
		cfg_we <= 0;
		span_last = last;
	endtask

	function automatic logic signed [lmst_pkg::DATA_W-1:0] rand_value();
		case ($urandom_range(0, 7))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $urandom;
			default: return $signed($urandom_range(0, 2000)) - 1000;
		endcase
	endfunction

	task automatic random_phase(int count, int unsigned last);
		logic [lmst_pkg::MODE_W-1:0] md;
		int unsigned lo, hi, pos, r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 19);
			md = r < 7 ? lmst_pkg::MODE_ADD : r < 12 ? lmst_pkg::MODE_LOWER :
				r < 19 ? lmst_pkg::MODE_QUERY : MODE_UNUSED;
			if ($urandom_range(0, 9) == 0) begin
				lo = $urandom_range(0, 1023);
				hi = $urandom_range(0, 1023);
				pos = $urandom_range(0, 1023);
			end else begin
				lo = $urandom_range(0, last);
				hi = $urandom_range(lo, last);
				pos = $urandom_range(0, last);
			end
			send_item(md, lo, hi, pos, rand_value());
		end
	endtask

	initial begin
		stim_row_t r;
		for (int i = 0; i < NODES; i++) begin
			tree_min[i] = 0;
			tree_lazy[i] = 0;
		end
		span_last = 1023;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		while (busy) @(posedge clk);

		// after reset every position holds zero
		add_row(lmst_pkg::MODE_QUERY, 0, 1023, 0, 0, 1, 0);
		add_row(lmst_pkg::MODE_QUERY, 5, 4, 0, 0, 1, lmst_pkg::NEUTRAL);
		add_row(MODE_UNUSED, 0, 1023, 3, 32'sh80000000, 0, 0);
		add_row(lmst_pkg::MODE_QUERY, 1023, 1023, 0, 0, 1, 0);
		add_row(lmst_pkg::MODE_ADD, 0, 1023, 0, 32'sh7fffffff, 0, 0);
		add_row(lmst_pkg::MODE_ADD, 0, 1023, 0, 32'sh7fffffff, 0, 0);
		add_row(lmst_pkg::MODE_QUERY, 0, 1023, 0, 0, 1, 32'sh7fffffff);
		add_row(lmst_pkg::MODE_ADD, 100, 200, 0, 32'sh80000000, 0, 0);
		add_row(lmst_pkg::MODE_ADD, 100, 200, 0, 32'sh80000000, 0, 0);
		add_row(lmst_pkg::MODE_QUERY, 150, 150, 0, 0, 1, 32'sh80000000);
		add_row(lmst_pkg::MODE_ADD, 10, 5, 0, -7, 0, 0);
		add_row(lmst_pkg::MODE_LOWER, 0, 0, 0, -5, 0, 0);
		add_row(lmst_pkg::MODE_LOWER, 0, 0, 1023, 12, 0, 0);
		add_row(lmst_pkg::MODE_LOWER, 0, 0, 7, 33, 0, 0);
		add_row(lmst_pkg::MODE_QUERY, 0, 99, 0, 0, 0, 0);
		add_row(lmst_pkg::MODE_QUERY, 201, 1023, 0, 0, 0, 0);
		add_row(lmst_pkg::MODE_ADD, 1, 1022, 0, -3, 0, 0);
		add_row(lmst_pkg::MODE_QUERY, 0, 1023, 0, 0, 0, 0);
		foreach (directed[i]) begin
			r = directed[i];
			send_item(r.md, r.lo, r.hi, r.pos, r.v);
			if (r.has_exp && min_queue[$] !== r.exp_min) begin
				$display("%0t: row %0d predictor disagrees, expected %0d, actual %0d",
					$time, i, r.exp_min, min_queue[$]);
				errors++;
			end
		end
		random_phase(200, 1023);
		drain();

		// small span, with ranges and positions past its end
		write_span(0);
		send_item(lmst_pkg::MODE_QUERY, 0, 1023, 0, 0);
		send_item(lmst_pkg::MODE_QUERY, 1, 1023, 0, 0);
		send_item(lmst_pkg::MODE_LOWER, 0, 0, 1, -9);
		random_phase(60, 0);
		drain();
		write_span(1);
		random_phase(120, 1);
		drain();
		write_span(10);
		send_item(lmst_pkg::MODE_QUERY, 11, 1023, 0, 0);
		random_phase(180, 10);
		drain();
		write_span($urandom_range(2, 1022));
		random_phase(120, span_last);
		drain();
		write_span(1023);
		random_phase(120, 1023);
		drain();

		$display("%0d items: %0d adds, %0d lowers, %0d queries, %0d unused-mode",
			n_items, n_adds, n_lowers, n_queries, n_nops);
		$display("spans 0, 1, 10, random and full; saturating values at both limits");
		if (errors == 0) begin
			$display("tb_lazy_min_segment_tree_unit passed");
		end else begin
			$display("tb_lazy_min_segment_tree_unit failed");
		end
		$finish;
	end
endmodule

// File: sim.f
rtl/lmst_pkg.sv
rtl/lmst_datapath.sv
rtl/lmst_ctrl.sv
rtl/lazy_min_segment_tree_unit.sv
rtl/lmst_checker.sv
tb/sv/tb_lazy_min_segment_tree_unit.sv
